/* hw/rtl/msfd_pkg.sv */
// Shared constants and types for the motor status frame deframer.
`default_nettype none

package msfd_pkg;

   localparam logic [7:0] HDR_A   = 8'hFA;
   localparam logic [7:0] HDR_B   = 8'hFD;
   localparam logic [7:0] TRAILER = 8'hFB;
   localparam logic [7:0] MIN_LEN = 8'd7;

   // Offset of the first data byte counted from the first header byte.
   localparam logic [7:0] DATA_START = 8'd5;
   // Byte count after the length byte (two header bytes plus length).
   localparam logic [7:0] BODY_START = 8'd3;

   localparam int MAX_MOTORS_DEF = 8;
   localparam int STAGE_DEPTH    = 8;
   localparam int STAGE_AW       = 3;
   localparam int BANK_COUNT     = 2;
   localparam int QUEUE_DEPTH    = 2;

   // One finished frame handed from the parser to the emitter.
   typedef struct packed {
      logic       cok;
      logic       fok;
      logic [3:0] n;
      logic       bank;
   } desc_type;

   // Read address into the staging banks.
   typedef struct packed {
      logic                bank;
      logic [STAGE_AW-1:0] idx;
   } stage_rd_type;

endpackage

`default_nettype wire

/* hw/rtl/msfd_if.sv */
// Valid/ready channel interfaces for received bytes and frame results.
`default_nettype none

interface msfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] motor_index;
   logic [7:0] position;
   logic [7:0] motor_state;
   logic       checksum_ok;
   logic       frame_ok;
   logic       last;

   modport source (output valid, output motor_index, output position, output motor_state,
                   output checksum_ok, output frame_ok, output last, input ready);
   modport sink   (input valid, input motor_index, input position, input motor_state,
                   input checksum_ok, input frame_ok, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/motor_status_frame_deframer_unit.sv */
// Top level of the motor status frame deframer: parser, descriptor queue, emitter.
//
//   channel  dir  handshake          beat
//   req_bus  in   valid/ready        rx_byte
//   rsp_bus  out  valid/ready        motor_index, position, motor_state,
//                                    checksum_ok, frame_ok, last
//   csr_*    in   csr_we             csr_wdata = commit_on_bad_checksum
//
// The parser takes one byte per cycle unless req_bus stalls. A frame's results leave
// the output register one per cycle unless rsp_bus stalls: one per pair, or a lone one for an error or empty frame.
// req_bus stalls only while two finished frames wait in the two-entry descriptor
// queue, since each good frame with pairs holds one of the two staging banks until emitted.
// Reset is synchronous; it clears control state and the motor table.
`default_nettype none

module motor_status_frame_deframer_unit #(
   parameter int MAX_MOTORS = msfd_pkg::MAX_MOTORS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   msfd_req_if.sink   req_bus,
   msfd_rsp_if.source rsp_bus,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   localparam int PAIR_LIMIT = (MAX_MOTORS < msfd_pkg::STAGE_DEPTH) ?
                               MAX_MOTORS : msfd_pkg::STAGE_DEPTH;

   logic                   commit_bad_ff;
   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_head_valid;
   msfd_pkg::desc_type     q_desc;
   msfd_pkg::desc_type     q_head;
   msfd_pkg::stage_rd_type stage_rd;
   logic [15:0]            stage_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         commit_bad_ff <= 1'b1;
      end else if (csr_we) begin
         commit_bad_ff <= csr_wdata;
      end
   end

   msfd_front #(.MAX_MOTORS(MAX_MOTORS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (q_desc),
      .stage_rd    (stage_rd),
      .stage_rdata (stage_rdata)
   );

   msfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   msfd_back #(.MAX_MOTORS(MAX_MOTORS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .commit_bad  (commit_bad_ff),
      .head_valid  (q_head_valid),
      .head        (q_head),
      .pop         (q_pop),
      .stage_rd    (stage_rd),
      .stage_rdata (stage_rdata),
      .rsp_bus     (rsp_bus)
   );

   // A descriptor is never pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("descriptor pushed into full queue");

   // Error results stand alone and carry no pair.
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.frame_ok) |->
         (rsp_bus.last && rsp_bus.motor_index == 3'd0 && rsp_bus.position == 8'd0))
      else $error("error result not a lone zeroed beat");

   // Pair numbers stay within the staged pair limit.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ({1'b0, rsp_bus.motor_index} < 4'(PAIR_LIMIT)))
      else $error("motor index beyond pair limit");

endmodule

`default_nettype wire

/* hw/rtl/msfd_front.sv */
// Byte parser: header hunt, length, body staging, checksum and trailer check.
`default_nettype none

module msfd_front #(
   parameter int MAX_MOTORS = msfd_pkg::MAX_MOTORS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   msfd_req_if.sink               req_bus,
   input  logic                   q_full,
   output logic                   q_push,
   output msfd_pkg::desc_type     q_desc,
   input  msfd_pkg::stage_rd_type stage_rd,
   output logic [15:0]            stage_rdata
);

   localparam int PAIR_LIMIT = (MAX_MOTORS < msfd_pkg::STAGE_DEPTH) ?
                               MAX_MOTORS : msfd_pkg::STAGE_DEPTH;

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_LEN,
      PH_BODY,
      PH_CHK,
      PH_TRAIL
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] sum_ff, sum_in;
   logic [3:0] pairs_ff, pairs_in;
   logic       bank_ff, bank_in;

   logic [7:0] stage_hi_ff [msfd_pkg::BANK_COUNT][msfd_pkg::STAGE_DEPTH];
   logic [7:0] stage_lo_ff [msfd_pkg::BANK_COUNT][msfd_pkg::STAGE_DEPTH];

   logic                          accept;
   logic [7:0]                    rx;
   logic [7:0]                    data_off;
   logic [6:0]                    pair_k;
   logic                          stage_we;
   logic                          stage_hi;
   logic [msfd_pkg::STAGE_AW-1:0] stage_k;

   // Hold off new bytes while the descriptor queue is full; both staging banks may then belong to the emitter.
   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rx            = req_bus.rx_byte;
   assign data_off      = count_ff - msfd_pkg::DATA_START;
   assign pair_k        = data_off[7:1];
   assign stage_k       = pair_k[msfd_pkg::STAGE_AW-1:0];

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      pairs_in = pairs_ff;
      bank_in  = bank_ff;
      q_push   = 1'b0;
      q_desc   = '0;
      stage_we = 1'b0;
      stage_hi = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (rx == msfd_pkg::HDR_A) phase_in = PH_HUNT2;
            end
            PH_HUNT2: begin
               if (rx == msfd_pkg::HDR_B) phase_in = PH_LEN;
               else if (rx != msfd_pkg::HDR_A) phase_in = PH_HUNT1;
            end
            PH_LEN: begin
               if (rx < msfd_pkg::MIN_LEN) begin
                  q_push   = 1'b1;
                  phase_in = PH_HUNT1;
               end else begin
                  len_in   = rx;
                  sum_in   = rx;
                  count_in = msfd_pkg::BODY_START;
                  pairs_in = '0;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               sum_in = sum_ff + rx;
               if (count_ff >= msfd_pkg::DATA_START && pair_k < 7'(PAIR_LIMIT)) begin
                  stage_we = 1'b1;
                  stage_hi = !data_off[0];
                  if (data_off[0]) pairs_in = {1'b0, stage_k} + 4'd1;
               end
               count_in = count_ff + 8'd1;
               if (count_in >= len_ff - 8'd2) phase_in = PH_CHK;
            end
            PH_CHK: begin
               sum_in   = sum_ff - rx;
               phase_in = PH_TRAIL;
            end
            PH_TRAIL: begin
               q_push      = 1'b1;
               q_desc.cok  = (sum_ff == 8'd0);
               q_desc.bank = bank_ff;
               if (rx == msfd_pkg::TRAILER) begin
                  q_desc.fok = 1'b1;
                  q_desc.n   = pairs_ff;
                  // Hand the bank over only when it carries pairs.
                  if (pairs_ff != 4'd0) bank_in = !bank_ff;
               end
               phase_in = PH_HUNT1;
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         count_ff <= '0;
         len_ff   <= '0;
         sum_ff   <= '0;
         pairs_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         pairs_ff <= pairs_in;
         bank_ff  <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_we) begin
         if (stage_hi) stage_hi_ff[bank_ff][stage_k] <= rx;
         else          stage_lo_ff[bank_ff][stage_k] <= rx;
      end
   end

   assign stage_rdata = {stage_hi_ff[stage_rd.bank][stage_rd.idx],
                         stage_lo_ff[stage_rd.bank][stage_rd.idx]};

endmodule

`default_nettype wire

/* hw/rtl/msfd_queue.sv */
// Two-entry queue of finished frame descriptors between parser and emitter.
`default_nettype none

module msfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  msfd_pkg::desc_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output msfd_pkg::desc_type head
);

   localparam int PTR_W = (msfd_pkg::QUEUE_DEPTH > 1) ? $clog2(msfd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(msfd_pkg::QUEUE_DEPTH + 1);

   msfd_pkg::desc_type entry_ff [msfd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (cnt_ff == CNT_W'(msfd_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(msfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(msfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

/* hw/rtl/msfd_back.sv */
// Result emitter: walks staged pairs, commits them if allowed, drives rsp.
`default_nettype none

module msfd_back #(
   parameter int MAX_MOTORS = msfd_pkg::MAX_MOTORS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   commit_bad,
   input  logic                   head_valid,
   input  msfd_pkg::desc_type     head,
   output logic                   pop,
   output msfd_pkg::stage_rd_type stage_rd,
   input  logic [15:0]            stage_rdata,
   msfd_rsp_if.source             rsp_bus
);

   localparam int PAIR_LIMIT = (MAX_MOTORS < msfd_pkg::STAGE_DEPTH) ?
                               MAX_MOTORS : msfd_pkg::STAGE_DEPTH;
   localparam int TBL_AW     = (PAIR_LIMIT > 1) ? $clog2(PAIR_LIMIT) : 1;

   logic [msfd_pkg::STAGE_AW-1:0] cnt_ff, cnt_in;
   logic                          valid_ff, valid_in;
   logic [2:0]                    index_ff;
   logic [7:0]                    pos_ff;
   logic [7:0]                    state_ff;
   logic                          cok_ff;
   logic                          fok_ff;
   logic                          last_ff;
   logic [15:0]                   motor_tbl_ff [PAIR_LIMIT];

   logic load;
   logic is_pair;
   logic last_pair;
   logic commit;

   assign load      = head_valid && (!valid_ff || rsp_bus.ready);
   assign is_pair   = head.fok && (head.n != 4'd0);
   assign last_pair = (({1'b0, cnt_ff} + 4'd1) == head.n);
   assign pop       = load && (!is_pair || last_pair);
   assign commit    = load && is_pair && (head.cok || commit_bad);

   assign stage_rd.bank = head.bank;
   assign stage_rd.idx  = cnt_ff;

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         cnt_in   = pop ? '0 : cnt_ff + 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Error and empty frames carry zeroed pair fields.
   always_ff @(posedge clock) begin
      if (load) begin
         cok_ff <= head.cok;
         fok_ff <= head.fok;
         if (is_pair) begin
            index_ff <= cnt_ff;
            pos_ff   <= stage_rdata[15:8];
            state_ff <= stage_rdata[7:0];
            last_ff  <= last_pair;
         end else begin
            index_ff <= '0;
            pos_ff   <= '0;
            state_ff <= '0;
            last_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAIR_LIMIT; i++) motor_tbl_ff[i] <= '0;
      end else if (commit) begin
         motor_tbl_ff[cnt_ff[TBL_AW-1:0]] <= stage_rdata;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.motor_index = index_ff;
   assign rsp_bus.position    = pos_ff;
   assign rsp_bus.motor_state = state_ff;
   assign rsp_bus.checksum_ok = cok_ff;
   assign rsp_bus.frame_ok    = fok_ff;
   assign rsp_bus.last        = last_ff;

endmodule

`default_nettype wire
